/* design/bint_pkg.sv */
// ----------------------------------------------------------------------------
// B+ tree internal node table: shared definitions
// Operation codes, cell actions and the control bundle that the node
// controller sends to every cell of the entry chain.
// ----------------------------------------------------------------------------
package bint_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 7;

  localparam logic [OpW-1:0] OP_CLEAR    = 3'd0;
  localparam logic [OpW-1:0] OP_NEW_ROOT = 3'd1;
  localparam logic [OpW-1:0] OP_LOOKUP   = 3'd2;
  localparam logic [OpW-1:0] OP_INSERT   = 3'd3;
  localparam logic [OpW-1:0] OP_REMOVE   = 3'd4;
  localparam logic [OpW-1:0] OP_FIND     = 3'd5;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_TAKE_LEFT,
    ACT_TAKE_RIGHT
  } cell_act_e;

  typedef struct packed {
    cell_act_e act;
    logic      cmp_en;
  } cell_ctl_t;

endpackage

/* design/bint_in_if.sv */
// ----------------------------------------------------------------------------
// B+ tree internal node table: request channel
// Valid/ready channel carrying one node operation.
// ----------------------------------------------------------------------------
interface bint_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] key;
  logic [31:0] child_a;
  logic [31:0] child_b;
  logic [6:0]  position;

  modport source (output valid, op, key, child_a, child_b, position, input ready);
  modport sink   (input valid, op, key, child_a, child_b, position, output ready);
endinterface

/* design/bint_out_if.sv */
// ----------------------------------------------------------------------------
// B+ tree internal node table: response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface bint_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] child_out;
  logic [6:0]  position_out;
  logic [6:0]  count_out;

  modport source (output valid, ok, child_out, position_out, count_out, input ready);
  modport sink   (input valid, ok, child_out, position_out, count_out, output ready);
endinterface

/* design/btree_internal_node_table_core.sv */
// ----------------------------------------------------------------------------
// B+ tree internal node table
// One internal node held in a chain of entry cells with a node controller.
// ----------------------------------------------------------------------------
// A request is latched on the edge that accepts it. In the compare state all
// cells compare their key and child against the latched request at once. In
// the execute state the controller decides, the cells shift or load in
// parallel and the response is registered. The request side reopens only after
// that, so a new request is not taken while the last one is still in flight.
// A response still waiting does not block the next request from entering, but
// that request holds in its execute state until the waiting response is
// taken.
module btree_internal_node_table_core #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned CHILD_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  bint_in_if.sink    req_i,
  bint_out_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > bint_pkg::PosW) ? CNT_W : bint_pkg::PosW;
  localparam logic [CHILD_WIDTH-1:0] INV_CHILD = '1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;

  logic [bint_pkg::OpW-1:0]   op_q;
  logic [KEY_WIDTH-1:0]       key_q;
  logic [CHILD_WIDTH-1:0]     ca_q, cb_q;
  logic [bint_pkg::PosW-1:0]  pos_q;

  logic [6:0]             max_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CHILD_WIDTH-1:0] lm_q, lm_d;

  logic                     rv_q;
  logic                     rok_q, rok_d;
  logic [bint_pkg::DataW-1:0] rchild_q, rchild_d;
  logic [bint_pkg::PosW-1:0]  rpos_q, rpos_d;

  logic [KEY_WIDTH-1:0]   ckey  [MAX_ENTRIES];
  logic [CHILD_WIDTH-1:0] cchld [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] le, lt, eq, vld;
  logic [MAX_ENTRIES-1:0] lev, ltv, eqv, bnd, first, ofail;
  logic [MAX_ENTRIES:0]   seen;
  bint_pkg::cell_ctl_t    ctl [MAX_ENTRIES];

  logic                   exec_go;
  logic [CNT_W-1:0]       found_pos;
  logic                   found;
  logic [CHILD_WIDTH-1:0] bnd_child;
  logic                   any_bnd, order_fail;
  logic [CMP_W-1:0]       cap, cnt_w, pos_w, at, rm_idx;
  logic                   ins_ok, rm_ok, nr_ok, lm_hit;

  assign req_i.ready = (state_q == S_IDLE);
  assign exec_go     = (state_q == S_EXEC) && (!rv_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (req_i.valid) state_d = S_CMP;
      S_CMP:   state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q  <= req_i.op;
      key_q <= KEY_WIDTH'(req_i.key);
      ca_q  <= CHILD_WIDTH'(req_i.child_a);
      cb_q  <= CHILD_WIDTH'(req_i.child_b);
      pos_q <= req_i.position;
    end
  end

  // Entry chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]   lk, rk;
    logic [CHILD_WIDTH-1:0] lc, rc;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign lc = '0;
    end else begin : g_mid
      assign lk = ckey[i-1];
      assign lc = cchld[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign rk = '0;
      assign rc = '0;
    end else begin : g_inner
      assign rk = ckey[i+1];
      assign rc = cchld[i+1];
    end

    bint_cell #(.KEY_WIDTH(KEY_WIDTH), .CHILD_WIDTH(CHILD_WIDTH)) u_cell (
      .clk_i,
      .ctl_i        (ctl[i]),
      .bkey_i       (key_q),
      .bchild_i     (cb_q),
      .find_i       (ca_q),
      .left_key_i   (lk),
      .left_child_i (lc),
      .right_key_i  (rk),
      .right_child_i(rc),
      .key_o        (ckey[i]),
      .child_o      (cchld[i]),
      .le_o         (le[i]),
      .lt_o         (lt[i]),
      .eq_o         (eq[i])
    );

    assign vld[i] = (CNT_W'(i) < count_q);
    assign lev[i] = le[i] & vld[i];
    assign ltv[i] = lt[i] & vld[i];
    assign eqv[i] = eq[i] & vld[i];
    assign first[i]    = eqv[i] & ~seen[i];
    assign seen[i+1]   = seen[i] | eqv[i];
    if (i == MAX_ENTRIES - 1) begin : g_bl
      assign bnd[i]   = lev[i];
      assign ofail[i] = first[i] & ~le[i];
    end else begin : g_bi
      assign bnd[i]   = lev[i] & ~lev[i+1];
      assign ofail[i] = first[i] & (ltv[i+1] | ~le[i]);
    end
  end
  assign seen[0] = 1'b0;

  always_comb begin
    found_pos = '0;
    bnd_child = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (first[i]) found_pos = found_pos | CNT_W'(i + 1);
      if (bnd[i])   bnd_child = bnd_child | cchld[i];
    end
  end

  assign found      = seen[MAX_ENTRIES];
  assign any_bnd    = |bnd;
  assign lm_hit     = (ca_q == lm_q);
  assign cnt_w      = CMP_W'(count_q);
  assign pos_w      = CMP_W'(pos_q);
  assign cap        = (max_q == '0 || CMP_W'(max_q) > CMP_W'(MAX_ENTRIES))
                      ? CMP_W'(MAX_ENTRIES) : CMP_W'(max_q);
  assign at         = lm_hit ? '0 : CMP_W'(found_pos);
  // leftmost match checks only the first separator
  assign order_fail = lm_hit ? ltv[0] : (|ofail);
  assign ins_ok     = (ca_q != INV_CHILD) && (cb_q != INV_CHILD) && (cnt_w < cap)
                      && (lm_hit || found) && !order_fail;
  assign nr_ok      = (ca_q != INV_CHILD) && (cb_q != INV_CHILD) && (count_q == '0);
  assign rm_ok      = (pos_w <= cnt_w);
  assign rm_idx     = (pos_w == '0) ? '0 : pos_w - CMP_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctl[i].cmp_en = (state_q == S_CMP);
      ctl[i].act    = bint_pkg::ACT_HOLD;
      if (exec_go) begin
        case (op_q)
          bint_pkg::OP_NEW_ROOT:
            if (nr_ok && i == 0) ctl[i].act = bint_pkg::ACT_LOAD;
          bint_pkg::OP_INSERT:
            if (ins_ok) begin
              if (CMP_W'(i) == at)     ctl[i].act = bint_pkg::ACT_LOAD;
              else if (CMP_W'(i) > at) ctl[i].act = bint_pkg::ACT_TAKE_LEFT;
            end
          bint_pkg::OP_REMOVE:
            if (rm_ok && count_q != '0 && CMP_W'(i) >= rm_idx)
              ctl[i].act = bint_pkg::ACT_TAKE_RIGHT;
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    lm_d     = lm_q;
    rok_d    = 1'b0;
    rchild_d = '0;
    rpos_d   = '0;
    case (op_q)
      bint_pkg::OP_CLEAR: begin
        count_d = '0;
        lm_d    = INV_CHILD;
        rok_d   = 1'b1;
      end
      bint_pkg::OP_NEW_ROOT:
        if (nr_ok) begin
          lm_d    = ca_q;
          count_d = CNT_W'(1);
          rok_d   = 1'b1;
        end
      bint_pkg::OP_LOOKUP: begin
        rchild_d = bint_pkg::DataW'(any_bnd ? bnd_child : lm_q);
        rok_d    = 1'b1;
      end
      bint_pkg::OP_INSERT:
        if (ins_ok) begin
          count_d = count_q + CNT_W'(1);
          rok_d   = 1'b1;
        end
      bint_pkg::OP_REMOVE:
        if (rm_ok) begin
          rok_d = 1'b1;
          if (count_q == '0) begin
            lm_d = INV_CHILD;
          end else begin
            if (pos_q == '0) lm_d = cchld[0];
            count_d = count_q - CNT_W'(1);
          end
        end
      bint_pkg::OP_FIND:
        if (ca_q != INV_CHILD && (lm_hit || found)) begin
          rok_d  = 1'b1;
          rpos_d = lm_hit ? '0 : bint_pkg::PosW'(found_pos);
        end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      lm_q    <= INV_CHILD;
      max_q   <= 7'd64;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (exec_go) begin
        count_q <= count_d;
        lm_q    <= lm_d;
        rv_q    <= 1'b1;
      end else if (rsp_o.ready) begin
        rv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      rok_q    <= rok_d;
      rchild_q <= rchild_d;
      rpos_q   <= rpos_d;
    end
  end

  assign rsp_o.valid        = rv_q;
  assign rsp_o.ok           = rok_q;
  assign rsp_o.child_out    = rchild_q;
  assign rsp_o.position_out = rpos_q;
  assign rsp_o.count_out    = bint_pkg::PosW'(count_q);

endmodule

/* design/bint_cell.sv */
// ----------------------------------------------------------------------------
// B+ tree internal node table: entry cell
// Holds one separator key and child id, compares them against the broadcast
// request, and loads, holds or shifts from a neighbor on command.
// ----------------------------------------------------------------------------
module bint_cell #(
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned CHILD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  bint_pkg::cell_ctl_t    ctl_i,
  input  logic [KEY_WIDTH-1:0]   bkey_i,
  input  logic [CHILD_WIDTH-1:0] bchild_i,
  input  logic [CHILD_WIDTH-1:0] find_i,
  input  logic [KEY_WIDTH-1:0]   left_key_i,
  input  logic [CHILD_WIDTH-1:0] left_child_i,
  input  logic [KEY_WIDTH-1:0]   right_key_i,
  input  logic [CHILD_WIDTH-1:0] right_child_i,
  output logic [KEY_WIDTH-1:0]   key_o,
  output logic [CHILD_WIDTH-1:0] child_o,
  output logic                   le_o,
  output logic                   lt_o,
  output logic                   eq_o
);

  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [CHILD_WIDTH-1:0] child_q, child_d;
  logic                   le_q, lt_q, eq_q;

  always_comb begin
    key_d   = key_q;
    child_d = child_q;
    case (ctl_i.act)
      bint_pkg::ACT_HOLD: begin
      end
      bint_pkg::ACT_LOAD: begin
        key_d   = bkey_i;
        child_d = bchild_i;
      end
      bint_pkg::ACT_TAKE_LEFT: begin
        key_d   = left_key_i;
        child_d = left_child_i;
      end
      bint_pkg::ACT_TAKE_RIGHT: begin
        key_d   = right_key_i;
        child_d = right_child_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    child_q <= child_d;
    if (ctl_i.cmp_en) begin
      le_q <= (key_q <= bkey_i);
      lt_q <= (key_q < bkey_i);
      eq_q <= (child_q == find_i);
    end
  end

  assign key_o   = key_q;
  assign child_o = child_q;
  assign le_o    = le_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

/* design/bint_checker.sv */
// ----------------------------------------------------------------------------
// B+ tree internal node table: port checker
// Watches the request and response channels of the node table.
// ----------------------------------------------------------------------------
module bint_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        ok_i,
  input logic [31:0] child_out_i,
  input logic [6:0]  position_out_i
);

  // hold a stalled response
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(child_out_i))
    else $error("response dropped or changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous one in flight");

  a_pos_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> position_out_i == 7'd0)
    else $error("position reported on failed operation");

  a_child_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> child_out_i == 32'd0)
    else $error("child reported on failed operation");

endmodule

bind btree_internal_node_table_core bint_checker u_bint_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .ok_i           (rsp_o.ok),
  .child_out_i    (rsp_o.child_out),
  .position_out_i (rsp_o.position_out)
);
